FILE: hw/rtl/gmlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gate motor move controller package
// Shared types, codes and defaults for the per-motor move sequencer.
// ----------------------------------------------------------------------------
package gmlc_pkg;

	localparam int MOTORS_DEF    = 4;
	localparam int TICK_BITS_DEF = 16;

	// Input modes, carried in tuser.
	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_CMD  = 2'd1;
	localparam logic [1:0] MODE_RUN  = 2'd2;

	// Sequencer phases.
	localparam logic [1:0] PH_INIT  = 2'd0;
	localparam logic [1:0] PH_CHECK = 2'd1;
	localparam logic [1:0] PH_START = 2'd2;
	localparam logic [1:0] PH_WAIT  = 2'd3;

	// Run status codes.
	localparam logic [1:0] ST_IDLE     = 2'h0;
	localparam logic [1:0] ST_MOVING   = 2'h1;
	localparam logic [1:0] ST_FINISHED = 2'h2;

	// Error flag bits.
	localparam logic [2:0] ERR_COM  = 3'd1;
	localparam logic [2:0] ERR_TIME = 3'd2;
	localparam logic [2:0] ERR_POS  = 3'd4;

	// Drive direction codes.
	localparam logic [1:0] DIR_BRAKE = 2'd0;
	localparam logic [1:0] DIR_FWD   = 2'd1;
	localparam logic [1:0] DIR_REV   = 2'd2;

	localparam logic [6:0] DUTY_MAX = 7'd100;

	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  motor;
		logic        direction;
		logic [6:0]  speed;
		logic [15:0] timeout;
		logic        up_limit;
		logic        down_limit;
	} item_t;

	typedef struct packed {
		logic        down_seen;
		logic        up_seen;
		logic [6:0]  duty;
		logic [1:0]  drive_dir;
		logic        power_on;
		logic        position_error;
		logic        timeout_error;
		logic        any_error;
		logic [1:0]  run_status;
		logic        busy_res;
		logic [1:0]  motor_id;
	} result_t;

	// Per-motor record, without the runtime counter.
	typedef struct packed {
		logic        active;
		logic        move_dir;
		logic [6:0]  move_speed;
		logic [15:0] move_limit;
		logic [1:0]  phase;
		logic [1:0]  status_code;
		logic [2:0]  error_bits;
		logic [1:0]  limit_levels;
		logic        pwr;
		logic [1:0]  ddir;
		logic [6:0]  dduty;
	} chan_t;

endpackage
`default_nettype wire

FILE: hw/rtl/gmlc_chan_bank.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gate motor channel bank
// Holds every motor's state and applies one item per cycle while fire is high.
// ----------------------------------------------------------------------------
module gmlc_chan_bank
	import gmlc_pkg::*;
#(
	parameter int MOTORS    = MOTORS_DEF,
	parameter int TICK_BITS = TICK_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    fire,
	input  wire item_t   item,
	output result_t      result
);

	localparam int IW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
	localparam int CW = (TICK_BITS > 16) ? TICK_BITS : 16;

	chan_t                 chan_q    [MOTORS];
	logic [TICK_BITS-1:0]  elapsed_q [MOTORS];

	logic [4:0]           m_ext;
	logic [IW-1:0]        idx;
	logic                 present;
	chan_t                rd;
	chan_t                nxt;
	logic [TICK_BITS-1:0] el_rd;
	logic                 el_clr;
	logic                 tgt;
	logic                 both;
	logic                 in_time;
	logic                 wr_en;

	assign m_ext   = {3'b000, item.motor};
	assign idx     = m_ext[IW-1:0];
	assign present = (m_ext < 5'(MOTORS));

	always_comb begin
		rd     = present ? chan_q[idx] : '0;
		el_rd  = present ? elapsed_q[idx] : '0;
		nxt    = rd;
		el_clr = 1'b0;
		tgt    = rd.move_dir ? item.down_limit : item.up_limit;
		both   = item.up_limit & item.down_limit;
		in_time = (CW'(el_rd) < CW'(rd.move_limit));
		case (item.mode)
			MODE_CMD: begin
				if (!rd.active) begin
					nxt.move_dir   = item.direction;
					nxt.move_speed = item.speed;
					nxt.move_limit = item.timeout;
					nxt.active     = 1'b1;
				end
			end
			MODE_RUN: begin
				if (rd.active) begin
					case (rd.phase)
						PH_INIT: begin
							nxt.error_bits  = '0;
							nxt.status_code = ST_MOVING;
							el_clr          = 1'b1;
							nxt.phase       = PH_CHECK;
						end
						PH_CHECK: begin
							if (both || tgt) begin
								nxt.phase       = PH_INIT;
								nxt.status_code = ST_FINISHED;
								nxt.active      = 1'b0;
								if (both) begin
									nxt.error_bits = rd.error_bits | ERR_COM | ERR_POS;
								end
							end else begin
								nxt.phase = PH_START;
							end
						end
						PH_START: begin
							nxt.ddir  = rd.move_dir ? DIR_REV : DIR_FWD;
							nxt.dduty = (rd.move_speed > DUTY_MAX) ? DUTY_MAX : rd.move_speed;
							nxt.pwr   = 1'b1;
							el_clr    = 1'b1;
							nxt.phase = PH_WAIT;
						end
						default: begin
							// Wait: the target limit stops the move; both limits or timeout stop with an error.
							if (both || !in_time || tgt) begin
								nxt.pwr         = 1'b0;
								nxt.dduty       = '0;
								nxt.ddir        = DIR_BRAKE;
								nxt.phase       = PH_INIT;
								nxt.status_code = ST_FINISHED;
								nxt.active      = 1'b0;
								if (both) begin
									nxt.error_bits = rd.error_bits | ERR_COM | ERR_POS;
								end else if (!in_time) begin
									nxt.error_bits = rd.error_bits | ERR_COM | ERR_TIME;
								end
							end
						end
					endcase
				end
				nxt.limit_levels = {item.down_limit, item.up_limit};
			end
			default: begin
			end
		endcase
	end

	assign wr_en = fire && present && ((item.mode == MODE_CMD) || (item.mode == MODE_RUN));

	always_comb begin
		result           = '0;
		result.motor_id  = item.motor;
		if (present) begin
			result.busy_res       = nxt.active;
			result.run_status     = nxt.status_code;
			result.any_error      = nxt.error_bits[0];
			result.timeout_error  = nxt.error_bits[1];
			result.position_error = nxt.error_bits[2];
			result.power_on       = nxt.pwr;
			result.drive_dir      = nxt.ddir;
			result.duty           = nxt.dduty;
			result.up_seen        = nxt.limit_levels[0];
			result.down_seen      = nxt.limit_levels[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOTORS; i++) begin
				chan_q[i]    <= '0;
				elapsed_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < MOTORS; i++) begin
				if (fire && (item.mode == MODE_TICK)) begin
					if (elapsed_q[i] != {TICK_BITS{1'b1}}) begin
						elapsed_q[i] <= elapsed_q[i] + 1'b1;
					end
				end else if (wr_en && (idx == IW'(i))) begin
					chan_q[i] <= nxt;
					if (el_clr) begin
						elapsed_q[i] <= '0;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/gate_motor_limit_move_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gate motor limit move controller
// Per-motor move sequencer with up and down limit switches and tick timeout.
// ----------------------------------------------------------------------------
//  Channel   Dir  Beat contents
//  s_axis    in   tuser: mode; tdata: motor, direction, speed, timeout, limits
//  m_axis    out  tdata: status of the addressed motor after the update
//
//  One beat per cycle is sustained while m_axis accepts; a beat lands in the
//  input register at the edge that takes it, and its result is loaded into
//  the result register at the edge that fires it. That edge also updates
//  the addressed motor, or on a tick every motor's counter, from the beat.
//  Reset clears every motor to idle, braked, power off, counters at zero.
//  While m_axis stalls with the result register full, that register holds;
//  s_tready falls only when both registers are full and m_axis stalls.
// ----------------------------------------------------------------------------
module gate_motor_limit_move_controller
	import gmlc_pkg::*;
#(
	parameter int MOTORS    = MOTORS_DEF,
	parameter int TICK_BITS = TICK_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // motor, direction, speed, timeout, up_limit, down_limit
	input  wire logic [1:0]  s_tuser,  // mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata   // motor_id, busy_res, run_status, any_error,
	                                   // timeout_error, position_error, power_on,
	                                   // drive_dir, duty, up_seen, down_seen
);

	logic    s1_valid_q;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t res_d;
	logic    adv_out;
	logic    fire;
	logic    in_take;

	assign adv_out  = !out_valid_q || m_tready;
	assign fire     = s1_valid_q && adv_out;
	assign s_tready = !s1_valid_q || adv_out;
	assign in_take  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				s1_valid_q <= s_tvalid;
			end
			if (adv_out) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.mode       <= s_tuser;
			item_s1.motor      <= s_tdata[1:0];
			item_s1.direction  <= s_tdata[2];
			item_s1.speed      <= s_tdata[9:3];
			item_s1.timeout    <= s_tdata[25:10];
			item_s1.up_limit   <= s_tdata[26];
			item_s1.down_limit <= s_tdata[27];
		end
		if (fire) begin
			res_q <= res_d;
		end
	end

	gmlc_chan_bank #(
		.MOTORS    (MOTORS),
		.TICK_BITS (TICK_BITS)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (res_d)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, res_q};

	// A beat leaving the input register lands as the result of the same motor.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (m_tvalid && (res_q.motor_id == $past(item_s1.motor))))
		else $error("result does not follow the processed beat");

	// A powered motor is never reported as braked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_q.power_on) |-> (res_q.drive_dir != DIR_BRAKE))
		else $error("power on while braked");

	// A motor that is not busy has its power off.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !res_q.busy_res) |-> !res_q.power_on)
		else $error("idle motor still powered");

	// Back-pressure only arises when the input register is occupied.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (s1_valid_q && out_valid_q))
		else $error("input stalled with free registers");

endmodule
`default_nettype wire
